// ===== hw/rtl/ilir_pkg.sv =====
// Package for the indexed list unit: request and status codes, sizing constants
// and the control bundle that the top level broadcasts to every cell.
// No dependencies.
`default_nettype none
package ilir_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int CAPACITY_MAX = 1024;
    localparam int AT_W = $clog2(CAPACITY_MAX + 1);
    localparam int VALUE_W = 32;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_APPEND = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_REMOVE_LAST = 3'd3;
    localparam logic [2:0] REQ_READ = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BOUNDS = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic            ins;
        logic            rem;
        logic            hit;
        logic [AT_W-1:0] at;
        logic [AT_W-1:0] hit_at;
    } cell_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ilir_cell.sv =====
// One cell of the list row: holds one entry and takes its neighbor's value on a shift.
// Depends on ilir_pkg.
`default_nettype none
module ilir_cell #(
    parameter int IDX = 0
) (
    input  wire logic                                   clk,
    input  wire ilir_pkg::cell_ctl_t                    ctl,
    input  wire logic signed [ilir_pkg::VALUE_W-1:0]    value_in,
    input  wire logic signed [ilir_pkg::VALUE_W-1:0]    left,
    input  wire logic signed [ilir_pkg::VALUE_W-1:0]    right,
    output logic signed [ilir_pkg::VALUE_W-1:0]         value,
    output logic signed [ilir_pkg::VALUE_W-1:0]         hit_value
);

    localparam logic [ilir_pkg::AT_W-1:0] MY_IDX = ilir_pkg::AT_W'(IDX);

    logic signed [ilir_pkg::VALUE_W-1:0] value_reg;
    logic signed [ilir_pkg::VALUE_W-1:0] value_next;
    logic signed [ilir_pkg::VALUE_W-1:0] hit_reg;
    logic signed [ilir_pkg::VALUE_W-1:0] hit_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.ins && (MY_IDX > ctl.at))
        begin
            value_next = left;
        end
        else if (ctl.ins && (MY_IDX == ctl.at))
        begin
            value_next = value_in;
        end
        else if (ctl.rem && (MY_IDX >= ctl.at))
        begin
            value_next = right;
        end
        hit_next = (ctl.hit && (MY_IDX == ctl.hit_at)) ? value_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        hit_reg <= hit_next;
    end

    assign value = value_reg;
    assign hit_value = hit_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_list_insert_remove_get_unit.sv =====
// Top level of the indexed list unit: request decode, length counter, row of cells
// and result register. Depends on ilir_pkg and ilir_cell.
//
// channel  direction  handshake          fields
// in       request    in_valid/in_stall  req_type, position, value_in
// out      result     out_valid/out_stall status, value_out, length
//
// On a request, the cells shift on the accept edge, the selected entry is gathered from the
// row on the next edge, and the result is held until taken. One request is in flight at a
// time. Reset clears the length and the handshake state; the cells are not cleared.
// A stalled result holds the unit, which stalls new requests until it is taken.
`default_nettype none
module indexed_list_insert_remove_get_unit #(
    parameter int CAPACITY = ilir_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [2:0]                           req_type,
    input  wire logic [5:0]                           position,
    input  wire logic signed [ilir_pkg::VALUE_W-1:0]  value_in,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [1:0]                                status,
    output logic signed [ilir_pkg::VALUE_W-1:0]       value_out,
    output logic [6:0]                                length
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = ilir_pkg::AT_W;
    localparam logic [AW-1:0] CAP_W = AW'(CAPACITY);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          busy_reg;
    logic          s1_valid_reg;
    logic [1:0]    s1_status_reg;
    logic [6:0]    s1_length_reg;
    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic signed [ilir_pkg::VALUE_W-1:0] value_reg;
    logic [6:0]    length_reg;

    logic          in_accept;
    logic          out_accept;
    logic [AW-1:0] cnt_w;
    logic [AW-1:0] pos_w;
    logic [1:0]    st;
    ilir_pkg::cell_ctl_t ctl;
    ilir_pkg::cell_ctl_t ctl_gated;
    logic signed [ilir_pkg::VALUE_W-1:0] gathered;

    logic signed [ilir_pkg::VALUE_W-1:0] cell_val [CAPACITY];
    logic signed [ilir_pkg::VALUE_W-1:0] cell_hit [CAPACITY];

    assign in_stall = busy_reg;
    assign in_accept = in_valid && !busy_reg;
    assign out_accept = out_valid_reg && !out_stall;
    assign cnt_w = AW'(count_reg);
    assign pos_w = AW'(position);

    always_comb
    begin
        st = ilir_pkg::ST_OK;
        ctl = '0;
        case (req_type)
            ilir_pkg::REQ_INSERT:
            begin
                if (pos_w > cnt_w)
                begin
                    st = ilir_pkg::ST_BOUNDS;
                end
                else if (cnt_w >= CAP_W)
                begin
                    st = ilir_pkg::ST_FULL;
                end
                else
                begin
                    ctl.ins = 1'b1;
                    ctl.at = pos_w;
                end
            end
            ilir_pkg::REQ_APPEND:
            begin
                if (cnt_w >= CAP_W)
                begin
                    st = ilir_pkg::ST_FULL;
                end
                else
                begin
                    ctl.ins = 1'b1;
                    ctl.at = cnt_w;
                end
            end
            ilir_pkg::REQ_REMOVE:
            begin
                if (pos_w >= cnt_w)
                begin
                    st = ilir_pkg::ST_BOUNDS;
                end
                else
                begin
                    ctl.rem = 1'b1;
                    ctl.at = pos_w;
                    ctl.hit = 1'b1;
                    ctl.hit_at = pos_w;
                end
            end
            ilir_pkg::REQ_REMOVE_LAST:
            begin
                if (cnt_w == '0)
                begin
                    st = ilir_pkg::ST_BOUNDS;
                end
                else
                begin
                    ctl.hit = 1'b1;
                    ctl.hit_at = cnt_w - AW'(1);
                end
            end
            ilir_pkg::REQ_READ:
            begin
                if (cnt_w == '0)
                begin
                    st = ilir_pkg::ST_EMPTY;
                end
                else if (pos_w >= cnt_w)
                begin
                    st = ilir_pkg::ST_BOUNDS;
                end
                else
                begin
                    ctl.hit = 1'b1;
                    ctl.hit_at = pos_w;
                end
            end
            default:
            begin
                st = ilir_pkg::ST_BOUNDS;
            end
        endcase
        ctl_gated = in_accept ? ctl : '0;
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_accept && ctl.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (in_accept && st == ilir_pkg::ST_OK &&
                 (req_type == ilir_pkg::REQ_REMOVE || req_type == ilir_pkg::REQ_REMOVE_LAST))
        begin
            count_next = count_reg - CW'(1);
        end
    end

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic signed [ilir_pkg::VALUE_W-1:0] left_val;
        logic signed [ilir_pkg::VALUE_W-1:0] right_val;
        if (k == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_left
            assign left_val = cell_val[k-1];
        end
        if (k == CAPACITY - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_right
            assign right_val = cell_val[k+1];
        end
        ilir_cell #(
            .IDX(k)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl_gated),
            .value_in (value_in),
            .left     (left_val),
            .right    (right_val),
            .value    (cell_val[k]),
            .hit_value(cell_hit[k])
        );
    end

    always_comb
    begin
        gathered = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            gathered = gathered | cell_hit[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            s1_valid_reg <= in_accept;
            if (in_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                busy_reg <= 1'b0;
            end
            if (s1_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_status_reg <= st;
            s1_length_reg <= 7'(count_next);
        end
        if (s1_valid_reg)
        begin
            status_reg <= s1_status_reg;
            value_reg <= gathered;
            length_reg <= s1_length_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign value_out = value_reg;
    assign length = length_reg;

    a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg || s1_valid_reg) |-> busy_reg)
        else $error("request accepted while a result is pending");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        AW'(count_reg) <= CAP_W)
        else $error("length exceeds capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && ctl.ins) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_failed_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ilir_pkg::ST_OK) |-> (value_reg == '0))
        else $error("failed request returned a value");

endmodule
`default_nettype wire

// ===== tb/sv/tb_indexed_list_insert_remove_get_unit.sv =====
// Self-checking testbench for indexed_list_insert_remove_get_unit: directed and random
// list requests under varying idle and stall patterns, checked against a mirror list.
// Depends on ilir_pkg and the unit's RTL.
module tb_indexed_list_insert_remove_get_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP = ilir_pkg::CAPACITY_DEFAULT;
    localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] REQ_LAST_UNUSED = 3'd7;

    class list_mirror;
        typedef struct {
            logic [1:0]         status;
            logic signed [31:0] value;
            logic [6:0]         length;
        } list_result_t;

        logic signed [31:0] cells [LIST_CAP];
        logic [6:0]         count = '0;
        list_result_t       pending_results [$];
        int                 errors = 0;
        int                 requests = 0;
        int                 status_seen [4] = '{0, 0, 0, 0};
        int                 full_hits = 0;
        int                 empty_hits = 0;

        function void apply_request(logic [2:0] req, logic [5:0] pos,
                                    logic signed [31:0] val);
            list_result_t r;
            int k;
            r.status = ilir_pkg::ST_OK;
            r.value = '0;
            case (req)
                ilir_pkg::REQ_INSERT:
                begin
                    if (pos > count) r.status = ilir_pkg::ST_BOUNDS;
                    else if (count >= LIST_CAP) r.status = ilir_pkg::ST_FULL;
                    else
                    begin
                        for (k = count; k > pos; k--) cells[k] = cells[k-1];
                        cells[pos] = val;
                        count++;
                    end
                end
                ilir_pkg::REQ_APPEND:
                begin
                    if (count >= LIST_CAP) r.status = ilir_pkg::ST_FULL;
                    else
                    begin
                        cells[count] = val;
                        count++;
                    end
                end
                ilir_pkg::REQ_REMOVE:
                begin
                    if (pos >= count) r.status = ilir_pkg::ST_BOUNDS;
                    else
                    begin
                        r.value = cells[pos];
                        for (k = pos; k + 1 < count; k++) cells[k] = cells[k+1];
                        count--;
                    end
                end
                ilir_pkg::REQ_REMOVE_LAST:
                begin
                    if (count == 0) r.status = ilir_pkg::ST_BOUNDS;
                    else
                    begin
                        r.value = cells[count-1];
                        count--;
                    end
                end
                ilir_pkg::REQ_READ:
                begin
                    if (count == 0) r.status = ilir_pkg::ST_EMPTY;
                    else if (pos >= count) r.status = ilir_pkg::ST_BOUNDS;
                    else r.value = cells[pos];
                end
                default: r.status = ilir_pkg::ST_BOUNDS;
            endcase
            r.length = count;
            requests++;
            status_seen[r.status]++;
            if (count == LIST_CAP) full_hits++;
            if (count == 0) empty_hits++;
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, logic signed [63:0] expected_v,
                                  logic signed [63:0] actual_v);
            if (expected_v !== actual_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, expected_v, actual_v);
                errors++;
            end
        endfunction

        function void compare_result(logic [1:0] st, logic signed [31:0] vo, logic [6:0] len);
            list_result_t r;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unrequested result, expected none, %s %0d value %0d length %0d",
                         $time, "actual status", st, vo, len);
                errors++;
                return;
            end
            r = pending_results.pop_front();
            check_field("status", r.status, st);
            check_field("value_out", r.value, vo);
            check_field("length", r.length, len);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         req_type = '0;
    logic [5:0]         position = '0;
    logic signed [31:0] value_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] value_out;
    logic [6:0]         length;

    logic               hold_go = 1'b0;
    int                 sender_idle_pct = 0;
    int                 recv_stall_pct = 0;
    list_mirror         mirror;

    indexed_list_insert_remove_get_unit #(.CAPACITY(LIST_CAP)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .position  (position),
        .value_in  (value_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .value_out (value_out),
        .length    (length)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("indexed_list_insert_remove_get_unit verification failed");
        $finish;
    end

    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go <= 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            mirror.compare_result(status, value_out, length);
    end

    task automatic send_request(input logic [2:0] req, input logic [5:0] pos,
                                input logic signed [31:0] val);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        position <= pos;
        value_in <= val;
        do
            @(posedge clk);
        while (in_stall);
        mirror.apply_request(req, pos, val);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_request(input int grow_pct);
        logic [2:0]         req;
        logic [5:0]         pos;
        logic signed [31:0] val;
        int                 cnt;
        int                 pick;
        cnt = mirror.count;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            req = 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
        else if (pick < 20)
            req = ilir_pkg::REQ_READ;
        else if ($urandom_range(0, 99) < grow_pct)
            req = $urandom_range(0, 1) ? ilir_pkg::REQ_APPEND : ilir_pkg::REQ_INSERT;
        else
            req = $urandom_range(0, 1) ? ilir_pkg::REQ_REMOVE_LAST : ilir_pkg::REQ_REMOVE;
        if ($urandom_range(0, 99) < 20 || (cnt == 0 && req != ilir_pkg::REQ_INSERT))
            pos = 6'($urandom_range(0, 63));
        else if (req == ilir_pkg::REQ_INSERT)
            pos = 6'($urandom_range(0, (cnt > 63) ? 63 : cnt));
        else
            pos = 6'($urandom_range(0, cnt - 1));
        case ($urandom_range(0, 9))
            0: val = 32'sh7FFF_FFFF;
            1: val = 32'sh8000_0000;
            2: val = '0;
            3: val = '1;
            default: val = $urandom;
        endcase
        send_request(req, pos, val);
    endtask

    task automatic random_phase(input int items, input int idle_pct, input int stall_pct,
                                input int grow_pct);
        wait_drain();
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) random_request(grow_pct);
    endtask

    initial
    begin
        mirror = new;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ilir_pkg::REQ_READ, 6'd0, 32'sd5);
        send_request(ilir_pkg::REQ_REMOVE_LAST, 6'd0, 32'sd0);
        send_request(ilir_pkg::REQ_REMOVE, 6'd0, 32'sd0);
        send_request(ilir_pkg::REQ_INSERT, 6'd1, 32'sd9);
        send_request(ilir_pkg::REQ_INSERT, 6'd0, 32'sh7FFF_FFFF);
        send_request(ilir_pkg::REQ_APPEND, 6'd63, 32'sh8000_0000);
        send_request(ilir_pkg::REQ_INSERT, 6'd1, -32'sd1);
        send_request(ilir_pkg::REQ_INSERT, 6'd3, 32'sd0);
        send_request(ilir_pkg::REQ_INSERT, 6'd63, 32'sd1);
        send_request(ilir_pkg::REQ_READ, 6'd0, 32'sd0);
        send_request(ilir_pkg::REQ_READ, 6'd3, 32'sd0);
        send_request(ilir_pkg::REQ_READ, 6'd4, 32'sd0);
        send_request(ilir_pkg::REQ_READ, 6'd63, 32'sd0);
        send_request(REQ_FIRST_UNUSED, 6'd63, 32'sh5555_5555);
        send_request(REQ_FIRST_UNUSED + 3'd1, 6'd0, 32'shAAAA_AAAA);
        send_request(REQ_LAST_UNUSED, 6'd2, -32'sd1);
        send_request(ilir_pkg::REQ_REMOVE, 6'd4, 32'sd0);
        send_request(ilir_pkg::REQ_REMOVE, 6'd1, 32'sd0);
        send_request(ilir_pkg::REQ_REMOVE_LAST, 6'd0, 32'sd0);
        send_request(ilir_pkg::REQ_REMOVE, 6'd0, 32'sd0);
        send_request(ilir_pkg::REQ_REMOVE_LAST, 6'd0, 32'sd0);
        send_request(ilir_pkg::REQ_REMOVE_LAST, 6'd0, 32'sd0);

        random_phase(200, 0, 0, 75);
        random_phase(150, 71, 0, 30);
        random_phase(150, 0, 71, 60);
        random_phase(150, 22, 22, 50);
        wait_drain();
        hold_go <= 1'b1;
        random_phase(60, 0, 0, 80);
        random_phase(150, 0, 0, 20);

        wait_drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d requests: %0d ok, %0d out of bounds, %0d empty reads, %0d full.",
                 mirror.requests, mirror.status_seen[ilir_pkg::ST_OK],
                 mirror.status_seen[ilir_pkg::ST_BOUNDS],
                 mirror.status_seen[ilir_pkg::ST_EMPTY], mirror.status_seen[ilir_pkg::ST_FULL]);
        $display("The list ended a request full %0d times and empty %0d times.",
                 mirror.full_hits, mirror.empty_hits);
        if (mirror.errors == 0)
            $display("indexed_list_insert_remove_get_unit verification clean");
        else
            $display("indexed_list_insert_remove_get_unit verification failed");
        $finish;
    end
endmodule

// ===== indexed_list_insert_remove_get_unit.f =====
hw/rtl/ilir_pkg.sv
hw/rtl/ilir_cell.sv
hw/rtl/indexed_list_insert_remove_get_unit.sv
tb/sv/tb_indexed_list_insert_remove_get_unit.sv
